// File: rtl/lcfp_pkg.sv
// Shared types and constants for the LED chaser with fading PWM.
// No dependencies; imported by the LED cell and the top level.
package lcfp_pkg;

    localparam int LED_PINS_W = 23;
    localparam int LEVEL_W    = 4;
    localparam int SPEED_W    = 6;
    localparam int CNT_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 32;

    localparam logic [SPEED_W-1:0] SPEED_MAX   = 6'd40;
    localparam logic [SPEED_W-1:0] SPEED_MIN   = 6'd1;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 6'd10;

    localparam logic [CFG_ADDR_W-1:0] REG_PWM_PERIOD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FADE_PERIOD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POLL_PERIOD = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SCALE  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_POLL,
        ST_DONE
    } lcfp_state_t;

    // Broadcast combinationally to every LED cell.
    typedef struct packed {
        logic               pwm_en;
        logic [LEVEL_W-1:0] phase;
        logic               fade_en;
        logic [LEVEL_W-1:0] fade_max;
        logic               dot_en;
        logic               dot_back;
        logic               set_all;
        logic               all_val;
    } cell_ctrl_t;

endpackage

// File: rtl/lcfp_cell.sv
// One LED cell: fade level, on/off target, dot token and pin bit.
// Depends on lcfp_pkg; the dot token passes to a neighbor cell on a dot step.
module lcfp_cell #(
    parameter bit DOT_RESET = 1'b0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcfp_pkg::cell_ctrl_t ctrl,
    input  logic                dot_lower_in,
    input  logic                dot_upper_in,
    output logic                dot_out,
    output logic                pin_out
);
    import lcfp_pkg::*;

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               target_reg, target_next;
    logic               dot_reg, dot_next;
    logic               pin_reg, pin_next;
    logic               dot_in;
    logic               tgt_base;

    always_comb begin
        dot_in      = ctrl.dot_back ? dot_upper_in : dot_lower_in;
        level_next  = level_reg;
        pin_next    = pin_reg;
        dot_next    = dot_reg;
        if (ctrl.pwm_en) begin
            pin_next = !(level_reg > ctrl.phase);
        end
        // fade uses the target as it stood before this cycle's dot step
        if (ctrl.fade_en) begin
            if (!target_reg && level_reg != '0) begin
                level_next = level_reg - 1'b1;
            end else if (target_reg && level_reg < ctrl.fade_max) begin
                level_next = level_reg + 1'b1;
            end
        end
        tgt_base    = ctrl.set_all ? ctrl.all_val : target_reg;
        target_next = tgt_base;
        if (ctrl.dot_en) begin
            dot_next = dot_in;
            if (dot_in) begin
                target_next = 1'b1;
            end else if (dot_reg) begin
                target_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            target_reg <= 1'b0;
            dot_reg    <= DOT_RESET;
            pin_reg    <= 1'b1;
        end else begin
            level_reg  <= level_next;
            target_reg <= target_next;
            dot_reg    <= dot_next;
            pin_reg    <= pin_next;
        end
    end

    assign dot_out = dot_reg;
    assign pin_out = pin_reg;

endmodule

// File: rtl/led_chaser_fade_pwm.sv
// Top level of the LED chaser: tick sequencer, counters, buttons, output register.
// Depends on lcfp_pkg and a ring of lcfp_cell instances, one per LED.
//
//  channel | dir | handshake         | contents
//  --------+-----+-------------------+--------------------------------------
//  s_      | in  | s_tvalid/s_tready | one tick: four button levels
//  m_      | out | m_tvalid/m_tready | pins, program, speed, lockout
//  cfg_    | in  | cfg_wr_en         | pwm/fade/poll periods, step scale
//
// An item passes through four states: accept, animation step, button poll, output load.
// The output load waits while the previous result is still held on m_.
// Reset is synchronous on aresetn and restores the register defaults; btn_reg, m_data_reg and limit_reg are not reset.
// The dot step is one shift of a token around the ring of cells.
module led_chaser_fade_pwm #(
    parameter int NUM_LEDS = 23
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] button_slow, [1] button_prev, [2] button_next, [3] button_fast
    input  logic [lcfp_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [22:0] led_pins, [23] active_program, [29:24] speed_value, [30] held
    output logic [lcfp_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [lcfp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lcfp_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import lcfp_pkg::*;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    lcfp_state_t state_reg, state_next;

    logic [LEVEL_W-1:0] pwm_period_reg;
    logic [7:0]         fade_period_reg;
    logic [7:0]         poll_period_reg;
    logic [9:0]         step_scale_reg;

    logic [3:0]         btn_reg, btn_next;
    logic [LEVEL_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   step_cnt_reg, step_cnt_next;
    logic [CNT_W-1:0]   poll_cnt_reg, poll_cnt_next;
    logic [CNT_W-1:0]   fade_cnt_reg, fade_cnt_next;
    logic [CNT_W-1:0]   limit_reg;
    logic               prog_reg, prog_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic               lock_reg, lock_next;
    logic               changed_reg, changed_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    cell_ctrl_t          ctrl;
    logic [NUM_LEDS-1:0] dot_w;
    logic [LED_PINS_W-1:0] pins_w;

    logic               pressed, fade_hit, step_hit, poll_hit;
    logic [LEVEL_W-1:0] phase_inc;
    logic [SPEED_W-1:0] speed_up;

    // step limit recomputed every cycle from the step scale and speed
    always_ff @(posedge aclk) begin
        limit_reg <= CNT_W'(step_scale_reg) * CNT_W'(speed_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg  <= 4'd6;
            fade_period_reg <= 8'd20;
            poll_period_reg <= 8'd10;
            step_scale_reg  <= 10'd100;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PWM_PERIOD:  pwm_period_reg  <= cfg_wr_data[LEVEL_W-1:0];
                REG_FADE_PERIOD: fade_period_reg <= cfg_wr_data[7:0];
                REG_POLL_PERIOD: poll_period_reg <= cfg_wr_data[7:0];
                REG_STEP_SCALE:  step_scale_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        btn_next      = btn_reg;
        phase_next    = phase_reg;
        step_cnt_next = step_cnt_reg;
        poll_cnt_next = poll_cnt_reg;
        fade_cnt_next = fade_cnt_reg;
        prog_next     = prog_reg;
        speed_next    = speed_reg;
        lock_next     = lock_reg;
        changed_next  = changed_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        s_tready      = 1'b0;

        ctrl          = '0;
        ctrl.phase    = phase_reg;
        ctrl.fade_max = pwm_period_reg;
        ctrl.dot_back = prog_reg;

        pressed  = |btn_reg;
        fade_hit = fade_cnt_reg > CNT_W'(fade_period_reg);
        step_hit = step_cnt_reg > limit_reg;
        poll_hit = poll_cnt_reg > CNT_W'(poll_period_reg);
        phase_inc = phase_reg + 1'b1;
        speed_up  = speed_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    btn_next   = s_tdata[3:0];
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!lock_reg) begin
                    ctrl.pwm_en = 1'b1;
                    phase_next  = (phase_inc >= pwm_period_reg) ? '0 : phase_inc;
                    if (fade_hit) begin
                        ctrl.fade_en  = 1'b1;
                        fade_cnt_next = '0;
                    end
                    if (step_hit) begin
                        ctrl.dot_en  = 1'b1;
                        step_cnt_next = '0;
                    end
                end
                state_next = ST_POLL;
            end
            ST_POLL: begin
                if (poll_hit) begin
                    if (pressed) begin
                        if (!lock_reg) begin
                            // slow first, then fast
                            if (btn_reg[0] && speed_reg < SPEED_MAX) begin
                                speed_up = speed_reg + 1'b1;
                            end
                            speed_next = (btn_reg[3] && speed_up > SPEED_MIN) ?
                                         speed_up - 1'b1 : speed_up;
                            prog_next = prog_reg ^ btn_reg[1] ^ btn_reg[2];
                            if (btn_reg[1] || btn_reg[2]) begin
                                ctrl.set_all = 1'b1;
                                ctrl.all_val = 1'b1;
                                changed_next = 1'b1;
                            end
                            lock_next = 1'b1;
                        end
                    end else if (lock_reg) begin
                        if (changed_reg) begin
                            changed_next = 1'b0;
                            ctrl.set_all = 1'b1;
                            ctrl.all_val = 1'b0;
                            ctrl.dot_en  = 1'b1;
                        end
                        lock_next = 1'b0;
                    end
                    poll_cnt_next = CNT_W'(1);
                end else begin
                    poll_cnt_next = sat_inc(poll_cnt_reg);
                end
                step_cnt_next = sat_inc(step_cnt_reg);
                fade_cnt_next = sat_inc(fade_cnt_reg);
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                // hold until the previous item has left the output register
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, lock_reg, speed_reg, prog_reg, pins_w};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            step_cnt_reg <= '0;
            poll_cnt_reg <= '0;
            fade_cnt_reg <= '0;
            prog_reg     <= 1'b0;
            speed_reg    <= SPEED_RESET;
            lock_reg     <= 1'b0;
            changed_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            step_cnt_reg <= step_cnt_next;
            poll_cnt_reg <= poll_cnt_next;
            fade_cnt_reg <= fade_cnt_next;
            prog_reg     <= prog_next;
            speed_reg    <= speed_next;
            lock_reg     <= lock_next;
            changed_reg  <= changed_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        btn_reg    <= btn_next;
        m_data_reg <= m_data_next;
    end

    genvar i;
    generate
        for (i = 0; i < LED_PINS_W; i++) begin : g_led
            if (i < NUM_LEDS) begin : g_cell
                localparam int LOWER = (i == 0) ? NUM_LEDS - 1 : i - 1;
                localparam int UPPER = (i == NUM_LEDS - 1) ? 0 : i + 1;
                lcfp_cell #(
                    .DOT_RESET(i == 0)
                ) u_cell (
                    .aclk        (aclk),
                    .aresetn     (aresetn),
                    .ctrl        (ctrl),
                    .dot_lower_in(dot_w[LOWER]),
                    .dot_upper_in(dot_w[UPPER]),
                    .dot_out     (dot_w[i]),
                    .pin_out     (pins_w[i])
                );
            end else begin : g_dark
                assign pins_w[i] = 1'b1;
            end
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
